/* rtl/core/lbt_pkg.sv */
// Shared types, widths and codes for the LRU byte budget tracker.
// No dependencies; every other file of the block imports this package.
package lbt_pkg;

    localparam int DEF_ENTRIES = 32;

    localparam int ZW = 5;    // zoom width
    localparam int CRW = 32;  // column / row width
    localparam int BW = 24;   // item size width
    localparam int GW = 40;   // budget width
    localparam int TW = 41;   // running total width
    localparam int PDW = 64;  // configuration data width
    localparam int PAW = 4;   // configuration address width

    localparam logic [GW-1:0] BUDGET_RESET = 40'd268435456;
    localparam logic [ZW-1:0] MAX_ZOOM_RESET = 5'd20;

    // operation codes
    localparam logic [1:0] FUNC_TOUCH = 2'd0;
    localparam logic [1:0] FUNC_PUT   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_MISS   = 2'd2;

    // configuration register indexes
    localparam logic REG_BUDGET   = 1'b0;
    localparam logic REG_MAX_ZOOM = 1'b1;

    // one table entry as stored in memory
    typedef struct packed {
        logic [ZW-1:0]  zoom;
        logic [CRW-1:0] x;
        logic [CRW-1:0] y;
        logic [BW-1:0]  bytes;
    } t_entry;

endpackage

/* rtl/core/lbt_store.sv */
// Recency-ordered entry memory: one write port, one registered read port.
// Depends on lbt_pkg for the entry type.
module lbt_store import lbt_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  t_entry                     i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output t_entry                     o_rdata
);
    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    // write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/lbt_cfg.sv */
// APB-style configuration registers: byte budget and largest zoom.
// Depends on lbt_pkg for widths, reset values and register indexes.
module lbt_cfg import lbt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [PDW-1:0] pwdata,
    output logic [PDW-1:0] prdata,
    output logic           pready,
    output logic [GW-1:0]  o_budget,
    output logic [ZW-1:0]  o_max_zoom
);
    logic [GW-1:0] r_budget;
    logic [ZW-1:0] r_max_zoom;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // take a write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget   <= BUDGET_RESET;
            r_max_zoom <= MAX_ZOOM_RESET;
        end else if (wr_en) begin
            if (paddr[3] == REG_BUDGET) begin
                r_budget <= pwdata[GW-1:0];
            end else begin
                r_max_zoom <= pwdata[ZW-1:0];
            end
        end
    end

    // return the addressed register
    always_comb begin
        if (paddr[3] == REG_MAX_ZOOM) begin
            prdata = {{(PDW-ZW){1'b0}}, r_max_zoom};
        end else begin
            prdata = {{(PDW-GW){1'b0}}, r_budget};
        end
    end

    assign o_budget   = r_budget;
    assign o_max_zoom = r_max_zoom;
endmodule

/* rtl/core/lbt_ctrl.sv */
// Sequencer: search, shift-to-front, insert and eviction passes over the
// entry memory. Depends on lbt_pkg; drives the ports of lbt_store.
module lbt_ctrl import lbt_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_func,
    input  logic [ZW-1:0]              i_tile_zoom,
    input  logic [CRW-1:0]             i_tile_x,
    input  logic [CRW-1:0]             i_tile_y,
    input  logic [BW-1:0]              i_item_bytes,
    input  logic [GW-1:0]              i_budget,
    input  logic [ZW-1:0]              i_max_zoom,
    output logic                       o_we,
    output logic [$clog2(ENTRIES)-1:0] o_waddr,
    output t_entry                     o_wdata,
    output logic                       o_re,
    output logic [$clog2(ENTRIES)-1:0] o_raddr,
    input  t_entry                     i_rdata,
    output logic                       o_res_valid,
    output logic [1:0]                 o_status,
    output logic                       o_evict_valid,
    output t_entry                     o_evict,
    output logic [TW-1:0]              o_total_bytes,
    output logic                       o_last
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_TAIL_RD, S_TAIL_DAT, S_TAIL_EMIT,
        S_SH_RD, S_SH_WR, S_WR0, S_BUD_CHK, S_BUD_RD, S_BUD_DAT, S_CLR_RD, S_CLR_DAT
    } t_state;

    t_state        r_state;
    logic [1:0]    r_func;
    t_entry        r_ent;
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_total;
    logic          r_ins;
    logic          r_emitted;
    logic          r_res_valid;
    logic [1:0]    r_status;
    logic          r_ev;
    t_entry        r_o_ent;
    logic          r_last;

    logic [TW-1:0] budget_ext;
    logic [TW-1:0] rd_bytes_ext;
    logic [TW-1:0] new_bytes_ext;
    logic [TW-1:0] sub_total;
    logic          key_hit;
    logic [AW-1:0] tail_addr;

    assign budget_ext    = {{(TW-GW){1'b0}}, i_budget};
    assign rd_bytes_ext  = {{(TW-BW){1'b0}}, i_rdata.bytes};
    assign new_bytes_ext = {{(TW-BW){1'b0}}, r_ent.bytes};
    assign sub_total     = r_total - rd_bytes_ext;
    assign key_hit       = (i_rdata.zoom == r_ent.zoom) && (i_rdata.x == r_ent.x)
                           && (i_rdata.y == r_ent.y);
    assign tail_addr     = AW'(r_cnt - CW'(1));

    // memory port requests
    always_comb begin
        o_re    = 1'b0;
        o_raddr = r_ptr;
        o_we    = 1'b0;
        o_waddr = r_ptr + AW'(1);
        o_wdata = i_rdata;
        unique case (r_state)
            S_SRCH_RD, S_SH_RD, S_CLR_RD: begin
                o_re = 1'b1;
            end
            S_TAIL_RD, S_BUD_RD: begin
                o_re    = 1'b1;
                o_raddr = tail_addr;
            end
            S_SH_WR: begin
                o_we = 1'b1;
            end
            S_WR0: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = r_ent;
            end
            default: begin
            end
        endcase
    end

    // state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_total     <= '0;
            r_res_valid <= 1'b0;
            r_emitted   <= 1'b0;
            r_ins       <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func    <= i_func;
                        r_ent     <= '{zoom: i_tile_zoom, x: i_tile_x, y: i_tile_y,
                                       bytes: i_item_bytes};
                        r_ptr     <= '0;
                        r_emitted <= 1'b0;
                        r_ins     <= 1'b0;
                        r_status  <= ST_OK;
                        r_ev      <= 1'b0;
                        r_last    <= 1'b1;
                        priority if (i_func == FUNC_CLEAR) begin
                            if (r_cnt == '0) begin
                                r_res_valid <= 1'b1;
                            end else begin
                                r_state <= S_CLR_RD;
                            end
                        end else if (i_func != FUNC_TOUCH && i_func != FUNC_PUT) begin
                            r_res_valid <= 1'b1;
                        end else if (i_tile_zoom > i_max_zoom) begin
                            r_status    <= ST_REJECT;
                            r_res_valid <= 1'b1;
                        end else if (r_cnt == '0) begin
                            // empty table: a touch misses, a put inserts
                            if (i_func == FUNC_TOUCH) begin
                                r_status    <= ST_MISS;
                                r_res_valid <= 1'b1;
                            end else begin
                                r_ins   <= 1'b1;
                                r_state <= S_WR0;
                            end
                        end else begin
                            r_state <= S_SRCH_RD;
                        end
                    end
                end
                S_SRCH_RD: begin
                    r_state <= S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    if (key_hit) begin
                        // present key: move it to the front
                        if (r_func == FUNC_PUT) begin
                            r_total <= sub_total + new_bytes_ext;
                        end else begin
                            r_ent.bytes <= i_rdata.bytes;
                        end
                        if (r_ptr == '0) begin
                            r_state <= S_WR0;
                        end else begin
                            r_ptr   <= r_ptr - AW'(1);
                            r_state <= S_SH_RD;
                        end
                    end else if (CW'(r_ptr) == r_cnt - CW'(1)) begin
                        if (r_func == FUNC_TOUCH) begin
                            r_status    <= ST_MISS;
                            r_res_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else if (r_cnt == CW'(ENTRIES)) begin
                            r_state <= S_TAIL_RD;
                        end else begin
                            r_ins   <= 1'b1;
                            r_state <= S_SH_RD;
                        end
                    end else begin
                        r_ptr   <= r_ptr + AW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_TAIL_RD: begin
                    r_state <= S_TAIL_DAT;
                end
                S_TAIL_DAT: begin
                    r_o_ent <= i_rdata;
                    r_total <= sub_total;
                    r_cnt   <= r_cnt - CW'(1);
                    r_state <= S_TAIL_EMIT;
                end
                S_TAIL_EMIT: begin
                    // final only if the insert leaves the total within budget
                    r_ev        <= 1'b1;
                    r_last      <= !((r_total + new_bytes_ext) > budget_ext);
                    r_res_valid <= 1'b1;
                    r_emitted   <= 1'b1;
                    r_ins       <= 1'b1;
                    r_ptr       <= tail_addr;
                    r_state     <= S_SH_RD;
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    if (r_ptr == '0) begin
                        r_state <= S_WR0;
                    end else begin
                        r_ptr   <= r_ptr - AW'(1);
                        r_state <= S_SH_RD;
                    end
                end
                S_WR0: begin
                    if (r_ins) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_total <= r_total + new_bytes_ext;
                    end
                    if (r_func == FUNC_TOUCH) begin
                        r_ev        <= 1'b0;
                        r_last      <= 1'b1;
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_BUD_CHK;
                    end
                end
                S_BUD_CHK: begin
                    if (r_total > budget_ext && r_cnt != '0) begin
                        r_state <= S_BUD_RD;
                    end else begin
                        if (!r_emitted) begin
                            r_ev        <= 1'b0;
                            r_last      <= 1'b1;
                            r_res_valid <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_BUD_RD: begin
                    r_state <= S_BUD_DAT;
                end
                S_BUD_DAT: begin
                    // drop the tail and decide whether another one goes
                    r_o_ent     <= i_rdata;
                    r_ev        <= 1'b1;
                    r_total     <= sub_total;
                    r_cnt       <= r_cnt - CW'(1);
                    r_res_valid <= 1'b1;
                    if (sub_total > budget_ext && r_cnt != CW'(1)) begin
                        r_last  <= 1'b0;
                        r_state <= S_BUD_RD;
                    end else begin
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_CLR_RD: begin
                    r_state <= S_CLR_DAT;
                end
                S_CLR_DAT: begin
                    // evict most recent first
                    r_o_ent     <= i_rdata;
                    r_ev        <= 1'b1;
                    r_total     <= sub_total;
                    r_cnt       <= r_cnt - CW'(1);
                    r_res_valid <= 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_last  <= 1'b0;
                        r_ptr   <= r_ptr + AW'(1);
                        r_state <= S_CLR_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_res_valid   = r_res_valid;
    assign o_status      = r_status;
    assign o_evict_valid = r_ev;
    assign o_evict       = r_ev ? r_o_ent : '0;
    assign o_total_bytes = r_total;
    assign o_last        = r_last;
endmodule

/* rtl/core/lru_byte_budget_tracker.sv */
// Top level of the LRU byte budget tracker: configuration, sequencer, memory.
// Depends on lbt_pkg, lbt_cfg, lbt_ctrl and lbt_store.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  command   | start / busy            | i_func, i_tile_zoom, i_tile_x, i_tile_y,
//            |                         | i_item_bytes
//  result    | o_res_valid (1 cycle)   | o_status, o_evict_*, o_total_bytes, o_last
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// Each probed entry of the key search is a read then a compare, and each position
// moved toward the front is a read then a write back, all through the
// single-read-port entry memory; each budget or clear eviction is a read then a
// data step, and the eviction that makes room in a full table adds an emit step.
// A command is taken only while busy is low. Reset (synchronous, active low)
// empties the table and loads the register defaults; the receiver cannot stall
// results.
module lru_byte_budget_tracker import lbt_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      i_func,
    input  logic [ZW-1:0]   i_tile_zoom,
    input  logic [CRW-1:0]  i_tile_x,
    input  logic [CRW-1:0]  i_tile_y,
    input  logic [BW-1:0]   i_item_bytes,
    output logic            o_res_valid,
    output logic [1:0]      o_status,
    output logic            o_evict_valid,
    output logic [ZW-1:0]   o_evict_zoom,
    output logic [CRW-1:0]  o_evict_x,
    output logic [CRW-1:0]  o_evict_y,
    output logic [BW-1:0]   o_evict_bytes,
    output logic [TW-1:0]   o_total_bytes,
    output logic            o_last,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [PAW-1:0]  paddr,
    input  logic [PDW-1:0]  pwdata,
    output logic [PDW-1:0]  prdata,
    output logic            pready
);
    localparam int AW = $clog2(ENTRIES);

    logic [GW-1:0] budget;
    logic [ZW-1:0] max_zoom;
    logic          we;
    logic          re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_entry        wdata;
    t_entry        rdata;
    t_entry        evict;

    lbt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_budget   (budget),
        .o_max_zoom (max_zoom)
    );

    lbt_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_tile_zoom   (i_tile_zoom),
        .i_tile_x      (i_tile_x),
        .i_tile_y      (i_tile_y),
        .i_item_bytes  (i_item_bytes),
        .i_budget      (budget),
        .i_max_zoom    (max_zoom),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_re          (re),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_res_valid   (o_res_valid),
        .o_status      (o_status),
        .o_evict_valid (o_evict_valid),
        .o_evict       (evict),
        .o_total_bytes (o_total_bytes),
        .o_last        (o_last)
    );

    lbt_store #(.ENTRIES(ENTRIES)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_evict_zoom  = evict.zoom;
    assign o_evict_x     = evict.x;
    assign o_evict_y     = evict.y;
    assign o_evict_bytes = evict.bytes;
endmodule

/* rtl/core/lbt_checker.sv */
// Port-level checks on the result stream of the tracker, bound to the top.
// Depends on lbt_pkg for status codes.
module lbt_checker import lbt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_res_valid,
    input logic [1:0] o_status,
    input logic       o_evict_valid,
    input logic       o_last
);
    // more results pending keeps the block busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_last |-> busy) else $error("non-final result while idle");

    // idle with no command gives no result next cycle
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !o_res_valid) else $error("result without command");

    // a result that evicts nothing ends its transaction
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_evict_valid |-> o_last) else $error("plain result not final");

    // reject and miss never evict
    a_status_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status != ST_OK |-> !o_evict_valid)
        else $error("eviction with error status");
endmodule

bind lru_byte_budget_tracker lbt_checker u_lbt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_res_valid   (o_res_valid),
    .o_status      (o_status),
    .o_evict_valid (o_evict_valid),
    .o_last        (o_last)
);

/* sim/lru_byte_budget_tracker_tb.sv */
// Self-checking testbench for the LRU byte budget tracker: directed and random
// touch, put and clear transactions checked against an in-bench table predictor.
// Depends on lbt_pkg and the lru_byte_budget_tracker RTL.
module lru_byte_budget_tracker_tb;
    import lbt_pkg::*;

    localparam int SLOTS = DEF_ENTRIES;
    localparam int SETTLE_CYCLES = 6 * SLOTS + 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [PAW-1:0] ADDR_BUDGET = PAW'(8 * REG_BUDGET);
    localparam logic [PAW-1:0] ADDR_MAX_ZOOM = PAW'(8 * REG_MAX_ZOOM);
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]     status;
        logic           ev;
        logic [ZW-1:0]  zoom;
        logic [CRW-1:0] x;
        logic [CRW-1:0] y;
        logic [BW-1:0]  bytes;
        logic [TW-1:0]  total;
        logic           last;
    } t_outcome;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [1:0]      i_func = '0;
    logic [ZW-1:0]   i_tile_zoom = '0;
    logic [CRW-1:0]  i_tile_x = '0;
    logic [CRW-1:0]  i_tile_y = '0;
    logic [BW-1:0]   i_item_bytes = '0;
    logic            o_res_valid;
    logic [1:0]      o_status;
    logic            o_evict_valid;
    logic [ZW-1:0]   o_evict_zoom;
    logic [CRW-1:0]  o_evict_x;
    logic [CRW-1:0]  o_evict_y;
    logic [BW-1:0]   o_evict_bytes;
    logic [TW-1:0]   o_total_bytes;
    logic            o_last;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [PAW-1:0]  paddr = '0;
    logic [PDW-1:0]  pwdata = '0;
    logic [PDW-1:0]  prdata;
    logic            pready;

    // predictor state: table, recency list, totals and registers
    t_entry          tile_table [SLOTS];
    logic [4:0]      recency [SLOTS];
    int              live_count;
    logic [TW-1:0]   tracked_bytes;
    logic [GW-1:0]   cur_budget;
    logic [ZW-1:0]   cur_max_zoom;
    t_outcome        pending_outcomes [$];

    int              mismatches = 0;
    int              cycle_count = 0;
    int              sender_idle_pct = 0;

    lru_byte_budget_tracker dut (.*);

    always #1 i_clk = ~i_clk;

    // bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[lru_byte_budget_tracker] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    // compare each result against the oldest expected outcome
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_res_valid) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result", 64'd1, 64'd0);
            end else begin
                e = pending_outcomes.pop_front();
                if (o_status !== e.status)
                    report_mismatch("status", 64'(o_status), 64'(e.status));
                if (o_evict_valid !== e.ev)
                    report_mismatch("evict_valid", 64'(o_evict_valid), 64'(e.ev));
                if (o_evict_zoom !== e.zoom)
                    report_mismatch("evict_zoom", 64'(o_evict_zoom), 64'(e.zoom));
                if (o_evict_x !== e.x)
                    report_mismatch("evict_x", 64'(o_evict_x), 64'(e.x));
                if (o_evict_y !== e.y)
                    report_mismatch("evict_y", 64'(o_evict_y), 64'(e.y));
                if (o_evict_bytes !== e.bytes)
                    report_mismatch("evict_bytes", 64'(o_evict_bytes), 64'(e.bytes));
                if (o_total_bytes !== e.total)
                    report_mismatch("total_bytes", 64'(o_total_bytes), 64'(e.total));
                if (o_last !== e.last)
                    report_mismatch("last", 64'(o_last), 64'(e.last));
            end
        end
    end

    // queue one outcome; slot < 0 means no eviction
    task automatic push_outcome(input logic [1:0] status, input int slot);
        t_outcome o;
        o.status = status;
        o.ev = (slot >= 0);
        o.zoom = (slot >= 0) ? tile_table[slot].zoom : '0;
        o.x = (slot >= 0) ? tile_table[slot].x : '0;
        o.y = (slot >= 0) ? tile_table[slot].y : '0;
        o.bytes = (slot >= 0) ? tile_table[slot].bytes : '0;
        o.total = tracked_bytes;
        o.last = 1'b0;
        pending_outcomes.push_back(o);
    endtask

    task automatic drop_lru_entry(inout int produced);
        int s;
        live_count--;
        s = recency[live_count];
        tracked_bytes = tracked_bytes - TW'(tile_table[s].bytes);
        push_outcome(ST_OK, s);
        produced++;
    endtask

    task automatic move_to_front(input int pos);
        logic [4:0] s;
        s = recency[pos];
        for (int p = pos; p > 0; p--) recency[p] = recency[p - 1];
        recency[0] = s;
    endtask

    // work out every result of one accepted transaction
    task automatic predict_transaction(input logic [1:0] func, input logic [ZW-1:0] zoom,
                                       input logic [CRW-1:0] x, input logic [CRW-1:0] y,
                                       input logic [BW-1:0] bytes);
        int produced;
        int hit;
        int s;
        bit used [SLOTS];
        produced = 0;
        hit = -1;
        if (func == FUNC_CLEAR) begin
            while (live_count > 0) begin
                s = recency[0];
                for (int p = 0; p < live_count - 1; p++) recency[p] = recency[p + 1];
                live_count--;
                tracked_bytes = tracked_bytes - TW'(tile_table[s].bytes);
                push_outcome(ST_OK, s);
                produced++;
            end
            if (produced == 0) push_outcome(ST_OK, -1);
        end else if (func == FUNC_UNUSED) begin
            push_outcome(ST_OK, -1);
        end else if (zoom > cur_max_zoom) begin
            push_outcome(ST_REJECT, -1);
        end else begin
            for (int p = 0; p < live_count; p++) begin
                s = recency[p];
                if (hit < 0 && tile_table[s].zoom == zoom && tile_table[s].x == x &&
                    tile_table[s].y == y) hit = p;
            end
            if (func == FUNC_TOUCH) begin
                if (hit >= 0) move_to_front(hit);
                push_outcome((hit >= 0) ? ST_OK : ST_MISS, -1);
            end else begin
                if (hit >= 0) begin
                    s = recency[hit];
                    tracked_bytes = tracked_bytes - TW'(tile_table[s].bytes) + TW'(bytes);
                    tile_table[s].bytes = bytes;
                    move_to_front(hit);
                end else begin
                    if (live_count >= SLOTS) drop_lru_entry(produced);
                    foreach (used[i]) used[i] = 1'b0;
                    for (int p = 0; p < live_count; p++) used[recency[p]] = 1'b1;
                    s = 0;
                    for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) s = i;
                    tile_table[s] = '{zoom: zoom, x: x, y: y, bytes: bytes};
                    recency[live_count] = 5'(s);
                    live_count++;
                    move_to_front(live_count - 1);
                    tracked_bytes = tracked_bytes + TW'(bytes);
                end
                while (tracked_bytes > TW'(cur_budget) && live_count > 0)
                    drop_lru_entry(produced);
                if (produced == 0) push_outcome(ST_OK, -1);
            end
        end
        pending_outcomes[$].last = 1'b1;
    endtask

    // drive one command, wait for acceptance, then maybe idle the sender
    task automatic send_command(input logic [1:0] func, input logic [ZW-1:0] zoom,
                                input logic [CRW-1:0] x, input logic [CRW-1:0] y,
                                input logic [BW-1:0] bytes);
        start <= 1'b1;
        i_func <= func;
        i_tile_zoom <= zoom;
        i_tile_x <= x;
        i_tile_y <= y;
        i_item_bytes <= bytes;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_transaction(func, zoom, x, y, bytes);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    // hold off until every expected result has arrived and the block is idle
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_outcomes.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write one register through the setup and access phases, then read it back
    task automatic write_register(input logic [PAW-1:0] addr, input logic [PDW-1:0] value);
        logic [PDW-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_BUDGET) cur_budget = value[GW-1:0];
        else cur_max_zoom = value[ZW-1:0];
        want = (addr == ADDR_BUDGET) ? PDW'(cur_budget) : PDW'(cur_max_zoom);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [GW-1:0] budget, input logic [ZW-1:0] max_zoom);
        wait_drained();
        write_register(ADDR_BUDGET, PDW'(budget));
        write_register(ADDR_MAX_ZOOM, PDW'(max_zoom));
    endtask

    // key from a small pool most of the time so touches and updates hit
    task automatic send_random(input int size_cap, input int pool);
        logic [1:0]     func;
        logic [ZW-1:0]  zoom;
        logic [CRW-1:0] x;
        logic [CRW-1:0] y;
        logic [BW-1:0]  bytes;
        int             pick;
        pick = $urandom_range(99);
        func = (pick < 40) ? FUNC_PUT : (pick < 85) ? FUNC_TOUCH :
               (pick < 95) ? FUNC_CLEAR : FUNC_UNUSED;
        if (func == FUNC_CLEAR && $urandom_range(3) != 0) func = FUNC_PUT;
        if ($urandom_range(9) != 0) begin
            zoom = ZW'($urandom_range(0, 3));
            x = $urandom_range(0, pool - 1);
            y = $urandom_range(0, 3);
        end else begin
            zoom = ZW'($urandom);
            x = $urandom;
            y = $urandom;
        end
        bytes = BW'($urandom_range(0, size_cap));
        send_command(func, zoom, x, y, bytes);
    endtask

    task automatic test_directed();
        configure(40'd1000, 5'd20);
        send_command(FUNC_TOUCH, 5'd0, 32'd0, 32'd0, 24'd0);
        send_command(FUNC_CLEAR, 5'd0, 32'd0, 32'd0, 24'd0);
        send_command(FUNC_PUT, 5'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd400);
        send_command(FUNC_PUT, 5'd0, 32'd0, 32'd0, 24'd300);
        send_command(FUNC_TOUCH, 5'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0);
        send_command(FUNC_TOUCH, 5'd21, 32'd0, 32'd0, 24'd0);
        send_command(FUNC_PUT, 5'd31, 32'd0, 32'd0, 24'd5);
        send_command(FUNC_TOUCH, 5'd1, 32'd9, 32'd9, 24'd0);
        send_command(FUNC_PUT, 5'd0, 32'd0, 32'd0, 24'd100);
        send_command(FUNC_PUT, 5'd2, 32'd5, 32'd6, 24'd700);
        send_command(FUNC_PUT, 5'd3, 32'd1, 32'd1, 24'hFF_FFFF);
        send_command(FUNC_UNUSED, 5'd7, 32'd1, 32'd2, 24'd3);
        send_command(FUNC_PUT, 5'd1, 32'd1, 32'd1, 24'd200);
        send_command(FUNC_PUT, 5'd1, 32'd2, 32'd1, 24'd200);
        send_command(FUNC_CLEAR, 5'd31, 32'hFFFF_FFFF, 32'd0, 24'hFF_FFFF);
        // zero budget drops even the new entry
        configure(40'd0, 5'd31);
        send_command(FUNC_PUT, 5'd31, 32'h5555_AAAA, 32'hAAAA_5555, 24'd1);
        send_command(FUNC_PUT, 5'd4, 32'd4, 32'd4, 24'd0);
        send_command(FUNC_CLEAR, 5'd0, 32'd0, 32'd0, 24'd0);
    endtask

    // fill past the table size so the tail makes room for new keys
    task automatic test_table_full();
        configure(40'hFF_FFFF_FFFF, 5'd31);
        for (int i = 0; i < 36; i++)
            send_command(FUNC_PUT, ZW'(i), CRW'(i), ~CRW'(i), BW'($urandom));
        send_command(FUNC_TOUCH, 5'd4, 32'd4, ~32'd4, 24'd0);
        send_command(FUNC_TOUCH, 5'd0, 32'd0, ~32'd0, 24'd0);
        configure(40'd1, 5'd0);
        send_command(FUNC_PUT, 5'd0, 32'd7, 32'd7, 24'd1);
        send_command(FUNC_PUT, 5'd0, 32'd8, 32'd7, 24'd2);
    endtask

    task automatic test_random_phase(input int count, input int size_cap, input int pool);
        for (int i = 0; i < count; i++) send_random(size_cap, pool);
    endtask

    initial begin
        live_count = 0;
        tracked_bytes = '0;
        cur_budget = BUDGET_RESET;
        cur_max_zoom = MAX_ZOOM_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 6;
        test_directed();
        test_table_full();
        configure(40'd20000, 5'd20);
        test_random_phase(90, 1500, 8);
        sender_idle_pct = 49;
        configure(40'hFF_FFFF_FFFF, 5'd31);
        test_random_phase(60, 24'hFF_FFFF, 16);
        configure(40'd5000, 5'd3);
        test_random_phase(60, 3000, 6);
        sender_idle_pct = 0;
        configure(40'd1, 5'd10);
        test_random_phase(60, 2, 4);
        configure(BUDGET_RESET, MAX_ZOOM_RESET);
        test_random_phase(82, 24'hFF_FFFF, 8);

        wait_drained();
        if (mismatches == 0) begin
            $display("[lru_byte_budget_tracker] OK");
        end else begin
            $display("[lru_byte_budget_tracker] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/lbt_pkg.sv
rtl/core/lbt_store.sv
rtl/core/lbt_cfg.sv
rtl/core/lbt_ctrl.sv
rtl/core/lru_byte_budget_tracker.sv
rtl/core/lbt_checker.sv
sim/lru_byte_budget_tracker_tb.sv
